[design/rar_pkg.sv]
// Shared types and constants for the rational arithmetic reducer.
package rar_pkg;
    localparam int OperandWidth = 31;
    localparam int MagWidth     = 62;
    localparam int NumWidth     = 63;
    localparam int DenWidth     = 61;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef logic [MagWidth-1:0] mag_t;

    // Request and response of the shared divider.
    typedef struct packed {
        logic start;
        mag_t dividend;
        mag_t divisor;
    } rar_div_req_t;

    typedef struct packed {
        logic done;
        mag_t quotient;
        mag_t remainder;
    } rar_div_rsp_t;
endpackage

[design/rar_mul.sv]
// Shared 31x31 signed multiplier with a registered product.
module rar_mul
    import rar_pkg::*;
(
    input  logic                           aclk,
    input  logic signed [OperandWidth-1:0] op_x,
    input  logic signed [OperandWidth-1:0] op_y,
    output logic signed [MagWidth-1:0]     prod
);
    logic signed [MagWidth-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MagWidth'(op_x) * MagWidth'(op_y);
    end

    assign prod = prod_reg;
endmodule

[design/rar_div.sv]
// Restoring divider, one quotient bit per cycle, shared by GCD and reduction.
module rar_div
    import rar_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  rar_div_req_t req,
    output rar_div_rsp_t rsp
);
    localparam int CntWidth = $clog2(MagWidth + 1);

    mag_t                quo_reg, quo_next;
    mag_t                rem_reg, rem_next;
    mag_t                dvs_reg;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [MagWidth:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[MagWidth-1]} - {1'b0, dvs_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = CntWidth'(MagWidth);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[MagWidth]) begin
                rem_next = trial[MagWidth-1:0];
                quo_next = {quo_reg[MagWidth-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[MagWidth-2:0], quo_reg[MagWidth-1]};
                quo_next = {quo_reg[MagWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntWidth'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (req.start) begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;
endmodule

[design/rational_arith_reduce_top.sv]
// Top level of the rational arithmetic reducer with GCD reduction.
//
// The block takes one item holding two fractions and an operation code and
// returns one item with the result reduced to lowest terms, the sign in the
// numerator and a positive denominator. A zero denominator (a zero input
// denominator other than den_b of a division, or division by a zero
// numerator) returns 0/0 with zero_den_error set; a zero numerator returns
// 0/1. The block works on one item at a time and holds s_tready low while
// busy. One shared 31x31 multiplier forms the cross products in states MUL0
// to MUL2, MUL3 takes the magnitudes and FORM checks for a zero numerator or
// denominator. Then one shared restoring divider, producing one quotient
// bit per cycle (62 iterations a call), runs Euclid's algorithm and
// finally the two reducing divisions.
// The result waits in an output register and s_tready rises again only
// after it has been taken.
module rational_arith_reduce_top
    import rar_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // num_a[30:0], den_a[61:31], num_b[92:62], den_b[123:93], func[125:124]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_num[62:0], res_den[123:63], zero_den_error[124]
    output logic [127:0] m_tdata
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL0  = 4'd1;
    localparam logic [3:0] ST_MUL1  = 4'd2;
    localparam logic [3:0] ST_MUL2  = 4'd3;
    localparam logic [3:0] ST_MUL3  = 4'd4;
    localparam logic [3:0] ST_FORM  = 4'd5;
    localparam logic [3:0] ST_GCD   = 4'd6;
    localparam logic [3:0] ST_GWAIT = 4'd7;
    localparam logic [3:0] ST_RNUM  = 4'd8;
    localparam logic [3:0] ST_RNW   = 4'd9;
    localparam logic [3:0] ST_RDEN  = 4'd10;
    localparam logic [3:0] ST_RDW   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0] state_reg;
    logic signed [OperandWidth-1:0] a_reg, c_reg, b_reg, d_reg;
    logic [1:0]  func_reg;
    logic signed [MagWidth-1:0] p0_reg, p1_reg;
    logic signed [MagWidth:0]   num_s;
    mag_t        nmag_reg, dmag_reg, gp_reg, gq_reg, g_reg;
    logic        neg_reg;
    logic signed [OperandWidth-1:0] mx, my;
    logic signed [MagWidth-1:0]     prod;
    rar_div_req_t div_req;
    rar_div_rsp_t div_rsp;
    logic [NumWidth-1:0] out_num_reg;
    logic [DenWidth-1:0] out_den_reg;
    logic                out_err_reg;

    rar_mul u_mul (.aclk(aclk), .op_x(mx), .op_y(my), .prod(prod));
    rar_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    // Multiplier operand selection: first the numerator pair, then the
    // denominator pair, depending on the operation.
    always_comb begin
        mx = a_reg;
        my = d_reg;
        unique case (state_reg)
            ST_MUL0: begin
                mx = a_reg;
                my = (func_reg == OP_MUL) ? b_reg : d_reg;
            end
            ST_MUL1: begin
                mx = b_reg;
                my = c_reg;
            end
            ST_MUL2: begin
                mx = c_reg;
                my = (func_reg == OP_DIV) ? b_reg : d_reg;
            end
            default: begin
                mx = a_reg;
                my = d_reg;
            end
        endcase
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = gp_reg;
        div_req.divisor  = gq_reg;
        unique case (state_reg)
            ST_GCD:  div_req.start = (gq_reg != '0);
            ST_RNUM: begin
                div_req.start    = 1'b1;
                div_req.dividend = nmag_reg;
                div_req.divisor  = g_reg;
            end
            ST_RDEN: begin
                div_req.start    = 1'b1;
                div_req.dividend = dmag_reg;
                div_req.divisor  = g_reg;
            end
            default: div_req.start = 1'b0;
        endcase
    end

    // The numerator: a single product, or the cross-product sum/difference.
    always_comb begin
        if (func_reg == OP_ADD) begin
            num_s = {p0_reg[MagWidth-1], p0_reg} + {p1_reg[MagWidth-1], p1_reg};
        end else if (func_reg == OP_SUB) begin
            num_s = {p0_reg[MagWidth-1], p0_reg} - {p1_reg[MagWidth-1], p1_reg};
        end else begin
            num_s = {p0_reg[MagWidth-1], p0_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        a_reg     <= s_tdata[30:0];
                        c_reg     <= s_tdata[61:31];
                        b_reg     <= s_tdata[92:62];
                        d_reg     <= s_tdata[123:93];
                        func_reg  <= s_tdata[125:124];
                        state_reg <= ST_MUL0;
                    end
                end
                ST_MUL0: state_reg <= ST_MUL1;
                ST_MUL1: begin
                    p0_reg    <= prod;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    p1_reg    <= prod;
                    state_reg <= ST_MUL3;
                end
                ST_MUL3: begin
                    // prod now holds the denominator; p1 is reused for it
                    // once the numerator has been folded in.
                    nmag_reg  <= num_s[MagWidth] ? mag_t'(-num_s) : num_s[MagWidth-1:0];
                    dmag_reg  <= prod[MagWidth-1] ? mag_t'(-prod) : mag_t'(prod);
                    neg_reg   <= num_s[MagWidth] ^ prod[MagWidth-1];
                    p1_reg    <= prod;
                    state_reg <= ST_FORM;
                end
                ST_FORM: begin
                    gp_reg <= nmag_reg;
                    gq_reg <= dmag_reg;
                    if (p1_reg == '0) begin
                        out_num_reg <= '0;
                        out_den_reg <= '0;
                        out_err_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end else if (nmag_reg == '0) begin
                        out_num_reg <= '0;
                        out_den_reg <= DenWidth'(1);
                        out_err_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                    end else begin
                        state_reg <= ST_GCD;
                    end
                end
                ST_GCD: begin
                    if (gq_reg == '0) begin
                        g_reg     <= gp_reg;
                        state_reg <= ST_RNUM;
                    end else begin
                        state_reg <= ST_GWAIT;
                    end
                end
                ST_GWAIT: begin
                    if (div_rsp.done) begin
                        gp_reg    <= gq_reg;
                        gq_reg    <= div_rsp.remainder;
                        state_reg <= ST_GCD;
                    end
                end
                ST_RNUM: state_reg <= ST_RNW;
                ST_RNW: begin
                    if (div_rsp.done) begin
                        out_num_reg <= neg_reg ? NumWidth'(-{1'b0, div_rsp.quotient})
                                               : NumWidth'(div_rsp.quotient);
                        state_reg   <= ST_RDEN;
                    end
                end
                ST_RDEN: state_reg <= ST_RDW;
                ST_RDW: begin
                    if (div_rsp.done) begin
                        out_den_reg <= div_rsp.quotient[DenWidth-1:0];
                        out_err_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {3'b000, out_err_reg, out_den_reg, out_num_reg};
endmodule

[design/rar_checker.sv]
// Port-level checker for the rational arithmetic reducer, bound to the top.
module rar_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);
    // Only one item is in flight: never ready for input while a result waits.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");

    // An accepted item drops ready in the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");

    // An error result is 0/0; otherwise the denominator is nonzero.
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[124] ? (m_tdata[123:0] == '0) : (m_tdata[123:63] != '0)))
        else $error("bad error result");

    // A pending result holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
endmodule

bind rational_arith_reduce_top rar_checker u_rar_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
